// ===== src/lrb_pkg.sv =====
// Package: shared types, codes and constants of the link reconnect backoff controller.
`timescale 1ns / 1ps
package lrb_pkg;

  // Width of the saturating elapsed-time counter
  localparam int TIME_BITS = 20;
  // Width of the millisecond configuration registers
  localparam int CFG_MS_W  = 20;
  localparam int RETRY_W   = 8;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  // Compare width that covers both the counter and the config values
  localparam int CMP_W     = 33;
  // Retry counts at or above this take the cap directly
  localparam int SHIFT_LIMIT = 40;
  localparam int SHIFT_W   = CFG_MS_W + SHIFT_LIMIT - 1;

  // Credential length limits
  localparam logic [7:0] SSID_MIN = 8'd1;
  localparam logic [7:0] SSID_MAX = 8'd32;
  localparam logic [7:0] PASS_MIN = 8'd8;
  localparam logic [7:0] PASS_MAX = 8'd63;

  // Register reset values
  localparam logic                AUTO_RST    = 1'b1;
  localparam logic [CFG_MS_W-1:0] TIMEOUT_RST = CFG_MS_W'(10000);
  localparam logic [CFG_MS_W-1:0] BASE_RST    = CFG_MS_W'(5000);
  localparam logic [RETRY_W-1:0]  MAXR_RST    = RETRY_W'(5);
  localparam logic [CFG_MS_W-1:0] CAP_RST     = CFG_MS_W'(60000);

  typedef enum logic [1:0] {
    ST_DISC    = 2'd0,
    ST_CONNING = 2'd1,
    ST_CONNED  = 2'd2,
    ST_FAIL    = 2'd3
  } link_state_t;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_CONNECT    = 3'd1,
    OP_DISCONNECT = 3'd2,
    OP_GOT_ADDR   = 3'd3,
    OP_LINK_LOST  = 3'd4,
    OP_CLEAR_CRED = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    REG_AUTO_RECONNECT = 3'd0,
    REG_TIMEOUT        = 3'd1,
    REG_BASE_DELAY     = 3'd2,
    REG_MAX_RETRIES    = 3'd3,
    REG_BACKOFF_CAP    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                auto_reconnect;
    logic [CFG_MS_W-1:0] connect_timeout_ms;
    logic [CFG_MS_W-1:0] retry_base_delay_ms;
    logic [RETRY_W-1:0]  max_retries;
    logic [CFG_MS_W-1:0] backoff_cap_ms;
  } cfg_t;

  typedef struct packed {
    link_state_t        link_status;
    logic [RETRY_W-1:0] retries_made;
    logic               station_on;
    logic               request_accepted;
    logic               attempt_started;
  } result_t;

endpackage

// ===== src/lrb_cfg.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module lrb_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lrb_pkg::ADDR_W-1:0] paddr,
  input  logic [lrb_pkg::DATA_W-1:0] pwdata,
  output logic [lrb_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output lrb_pkg::cfg_t              cfg
);

  logic                  wr_en;
  lrb_pkg::reg_idx_t     idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = lrb_pkg::reg_idx_t'(paddr[lrb_pkg::ADDR_W-1:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_reconnect      <= lrb_pkg::AUTO_RST;
      cfg.connect_timeout_ms  <= lrb_pkg::TIMEOUT_RST;
      cfg.retry_base_delay_ms <= lrb_pkg::BASE_RST;
      cfg.max_retries         <= lrb_pkg::MAXR_RST;
      cfg.backoff_cap_ms      <= lrb_pkg::CAP_RST;
    end else if (wr_en) begin
      case (idx)
        lrb_pkg::REG_AUTO_RECONNECT: cfg.auto_reconnect <= pwdata[0];
        lrb_pkg::REG_TIMEOUT:
          cfg.connect_timeout_ms <= pwdata[lrb_pkg::CFG_MS_W-1:0];
        lrb_pkg::REG_BASE_DELAY:
          cfg.retry_base_delay_ms <= pwdata[lrb_pkg::CFG_MS_W-1:0];
        lrb_pkg::REG_MAX_RETRIES:
          cfg.max_retries <= pwdata[lrb_pkg::RETRY_W-1:0];
        lrb_pkg::REG_BACKOFF_CAP:
          cfg.backoff_cap_ms <= pwdata[lrb_pkg::CFG_MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      lrb_pkg::REG_AUTO_RECONNECT:
        prdata = lrb_pkg::DATA_W'(cfg.auto_reconnect);
      lrb_pkg::REG_TIMEOUT:     prdata = lrb_pkg::DATA_W'(cfg.connect_timeout_ms);
      lrb_pkg::REG_BASE_DELAY:  prdata = lrb_pkg::DATA_W'(cfg.retry_base_delay_ms);
      lrb_pkg::REG_MAX_RETRIES: prdata = lrb_pkg::DATA_W'(cfg.max_retries);
      lrb_pkg::REG_BACKOFF_CAP: prdata = lrb_pkg::DATA_W'(cfg.backoff_cap_ms);
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== src/lrb_core.sv =====
// Link state machine, elapsed timer, retry counter and backoff compare.
`timescale 1ns / 1ps
module lrb_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [2:0]           op,
  input  logic [7:0]           ssid_length,
  input  logic [7:0]           password_length,
  input  lrb_pkg::cfg_t        cfg,
  output lrb_pkg::result_t     res
);

  localparam logic [lrb_pkg::TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [lrb_pkg::RETRY_W-1:0]   RETRY_MAX = '1;

  lrb_pkg::link_state_t              st, st_next;
  logic                              enabled, enabled_next;
  logic                              cred, cred_next;
  logic [lrb_pkg::TIME_BITS-1:0]     elapsed, elapsed_next;
  logic [lrb_pkg::RETRY_W-1:0]       retry, retry_next;
  logic                              accepted, started;

  lrb_pkg::op_t                      op_c;
  logic [lrb_pkg::TIME_BITS-1:0]     elapsed_inc;
  logic [lrb_pkg::RETRY_W-1:0]       retry_inc;
  logic [lrb_pkg::SHIFT_W-1:0]       shifted;
  logic [lrb_pkg::CFG_MS_W-1:0]      delay;
  logic                              try_ok;
  logic                              timed_out;
  logic                              creds_ok;

  assign op_c = lrb_pkg::op_t'(op);

  // Saturating increments
  assign elapsed_inc = (elapsed == TIME_MAX) ? elapsed :
                       elapsed + lrb_pkg::TIME_BITS'(1);
  assign retry_inc   = (retry == RETRY_MAX) ? retry : retry + lrb_pkg::RETRY_W'(1);

  // Backoff delay: base shifted by retry count, capped
  always_comb begin
    shifted = lrb_pkg::SHIFT_W'(cfg.retry_base_delay_ms) << retry[5:0];
    if (retry >= lrb_pkg::RETRY_W'(lrb_pkg::SHIFT_LIMIT) ||
        shifted > lrb_pkg::SHIFT_W'(cfg.backoff_cap_ms))
      delay = cfg.backoff_cap_ms;
    else
      delay = shifted[lrb_pkg::CFG_MS_W-1:0];
  end

  assign try_ok    = lrb_pkg::CMP_W'(elapsed_inc) >= lrb_pkg::CMP_W'(delay);
  assign timed_out = lrb_pkg::CMP_W'(elapsed_inc) >
                     lrb_pkg::CMP_W'(cfg.connect_timeout_ms);

  // Credential length check
  assign creds_ok = ssid_length >= lrb_pkg::SSID_MIN &&
                    ssid_length <= lrb_pkg::SSID_MAX &&
                    (password_length == 8'd0 ||
                     (password_length >= lrb_pkg::PASS_MIN &&
                      password_length <= lrb_pkg::PASS_MAX));

  // Next state
  always_comb begin
    st_next      = st;
    enabled_next = enabled;
    cred_next    = cred;
    elapsed_next = elapsed;
    retry_next   = retry;
    accepted     = 1'b1;
    started      = 1'b0;
    case (op_c)
      lrb_pkg::OP_TICK: begin
        elapsed_next = elapsed_inc;
        if (enabled && st == lrb_pkg::ST_DISC && cfg.auto_reconnect && cred) begin
          // automatic restart from disconnected
          if (try_ok) begin
            st_next      = lrb_pkg::ST_CONNING;
            elapsed_next = '0;
            retry_next   = retry_inc;
            started      = 1'b1;
          end
        end else if (st == lrb_pkg::ST_CONNING && timed_out) begin
          // attempt timed out: retry or give up
          if (retry < cfg.max_retries) begin
            if (try_ok) begin
              st_next      = lrb_pkg::ST_CONNING;
              elapsed_next = '0;
              retry_next   = retry_inc;
              started      = 1'b1;
            end else begin
              st_next = lrb_pkg::ST_FAIL;
            end
          end else begin
            st_next = lrb_pkg::ST_DISC;
          end
        end
      end
      lrb_pkg::OP_CONNECT: begin
        if (creds_ok) begin
          cred_next    = 1'b1;
          enabled_next = 1'b1;
          st_next      = lrb_pkg::ST_CONNING;
          elapsed_next = '0;
          retry_next   = '0;
          started      = 1'b1;
        end else begin
          accepted = 1'b0;
        end
      end
      lrb_pkg::OP_DISCONNECT: begin
        if (enabled) begin
          enabled_next = 1'b0;
          st_next      = lrb_pkg::ST_DISC;
        end
      end
      lrb_pkg::OP_GOT_ADDR: begin
        st_next    = lrb_pkg::ST_CONNED;
        retry_next = '0;
      end
      lrb_pkg::OP_LINK_LOST: begin
        if (st == lrb_pkg::ST_CONNED)
          st_next = lrb_pkg::ST_DISC;
      end
      lrb_pkg::OP_CLEAR_CRED: begin
        cred_next = 1'b0;
      end
      default: ;
    endcase
  end

  // Result of this request
  always_comb begin
    res.link_status      = st_next;
    res.retries_made     = retry_next;
    res.station_on       = enabled_next;
    res.request_accepted = accepted;
    res.attempt_started  = started;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= lrb_pkg::ST_DISC;
      enabled <= 1'b0;
      cred    <= 1'b0;
      elapsed <= '0;
      retry   <= '0;
    end else if (fire) begin
      st      <= st_next;
      enabled <= enabled_next;
      cred    <= cred_next;
      elapsed <= elapsed_next;
      retry   <= retry_next;
    end
  end

endmodule

// ===== src/link_reconnect_backoff_controller_top.sv =====
// Top level of the link reconnect backoff controller.
`timescale 1ns / 1ps
// Usage:
//   Request channel: in_valid/in_stall with op, ssid_length, password_length.
//   Op codes: tick (one millisecond), connect, disconnect, got address,
//   link lost, clear credentials. Every request yields exactly one result.
//   Result channel: out_valid/out_stall with link_status, retries_made,
//   station_on, request_accepted, attempt_started.
//   A request goes from the input register through the state update into
//   the result register. Throughput: one request per cycle while out_stall
//   does not hold the result; the state update is a single pass of
//   compares, one barrel shift and counter increments.
//   When out_stall holds the result, the input register still takes one more
//   request; in_stall rises only when both registers are full.
//   The APB-style port sets auto reconnect, timeout, base delay, retry limit
//   and backoff cap; write it only while no request is in flight.
//   Synchronous reset empties both registers and returns the link to
//   disconnected, station off, no credentials, counters zero and the
//   configuration to its defaults.
module link_reconnect_backoff_controller_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 op,
  input  logic [7:0]                 ssid_length,
  input  logic [7:0]                 password_length,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 link_status,
  output logic [7:0]                 retries_made,
  output logic                       station_on,
  output logic                       request_accepted,
  output logic                       attempt_started,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lrb_pkg::ADDR_W-1:0] paddr,
  input  logic [lrb_pkg::DATA_W-1:0] pwdata,
  output logic [lrb_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  lrb_pkg::cfg_t    cfg;
  lrb_pkg::result_t res;

  logic       in_full;
  logic [2:0] op_q;
  logic [7:0] ssid_q;
  logic [7:0] pass_q;
  logic       accept;
  logic       advance;

  lrb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake control
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op;
      ssid_q <= ssid_length;
      pass_q <= password_length;
    end
  end

  lrb_core u_core (
    .clk             (clk),
    .rst             (rst),
    .fire            (advance),
    .op              (op_q),
    .ssid_length     (ssid_q),
    .password_length (pass_q),
    .cfg             (cfg),
    .res             (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      link_status      <= res.link_status;
      retries_made     <= res.retries_made;
      station_on       <= res.station_on;
      request_accepted <= res.request_accepted;
      attempt_started  <= res.attempt_started;
    end
  end

  // Checks
  a_start_conning: assert property (@(posedge clk) disable iff (rst)
    out_valid && attempt_started |-> link_status == lrb_pkg::ST_CONNING)
    else $error("attempt started without connecting status");

  a_reject_no_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && !request_accepted |-> !attempt_started)
    else $error("rejected request started an attempt");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_full)
    else $error("pipeline not empty after reset");

endmodule
